[hdl/fcm_pkg.sv]
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared types and constants of the circular-delay-line FIR MAC core.
// ----------------------------------------------------------------------------
package fcm_pkg;

  localparam int DATA_W     = 16;
  localparam int COEF_IDX_W = 6;
  localparam int TAP_CNT_W  = 7;
  localparam int SHIFT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int IN_TDATA_W = 24;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SHIFT = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic                      coef_ok;
    logic [COEF_IDX_W-1:0]     coef_idx;
    logic signed [DATA_W-1:0]  value;
  } item_t;

endpackage

[hdl/fir_filter_circular_mac_core.sv]
// ----------------------------------------------------------------------------
// fir_filter_circular_mac_core
// Direct-form FIR filter with a circular delay line and one shared MAC.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata / data           | tuser
//  in_      | slave     | [5:0] coef_index,      | opcode (0 sample, 1 load)
//           |           | [21:6] value           |
//  out_     | master    | [15:0] sample_out      | saturated
//  cfg_     | slave     | index 0 taps in use,   | -
//           |           | index 1 output_shift   |
//
//  A load word with an in-range index is written as it leaves the queue; a
//  sample word is summed by the single MAC stepping one tap per cycle
//  through the one-read-port coefficient and delay memories. After reset
//  both memories are cleared and in_tready stays low meanwhile. A two-word
//  queue decouples intake from the MAC, and the output register lets the
//  next word start while a result waits.
// ----------------------------------------------------------------------------
module fir_filter_circular_mac_core #(
  parameter int MAX_TAPS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fcm_pkg::IN_TDATA_W-1:0]   in_tdata,   // coef_index, value, pad
  input  logic                             in_tuser,   // opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fcm_pkg::DATA_W-1:0]       out_tdata,  // sample_out
  output logic                             out_tuser   // saturated
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW = $clog2(MAX_TAPS + 1);
  localparam int QW = $bits(fcm_pkg::item_t) + TW;

  logic                          busy;
  logic                          q_push, q_ready, q_pop, q_valid;
  fcm_pkg::item_t                f_item, b_item;
  logic [TW-1:0]                 f_taps, b_taps;
  logic [QW-1:0]                 q_out;
  logic [fcm_pkg::SHIFT_W-1:0]   shift;

  fcm_front #(.MAX_TAPS(MAX_TAPS), .TW(TW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .busy      (busy),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_item    (f_item),
    .q_taps    (f_taps),
    .shift     (shift)
  );

  fcm_queue #(.W(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  ({f_taps, f_item}),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_data   (q_out),
    .pop_valid  (q_valid)
  );

  assign b_item = q_out[$bits(fcm_pkg::item_t)-1:0];
  assign b_taps = q_out[QW-1 -: TW];

  fcm_back #(.MAX_TAPS(MAX_TAPS), .TW(TW), .AW(AW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (b_item),
    .q_taps     (b_taps),
    .q_pop      (q_pop),
    .shift      (shift),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[hdl/fcm_queue.sv]
// ----------------------------------------------------------------------------
// fcm_queue
// Two-entry word queue between the front and the back of the core.
// ----------------------------------------------------------------------------
module fcm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         pop_valid
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/fcm_front.sv]
// ----------------------------------------------------------------------------
// fcm_front
// Holds the configuration registers, accepts input words and classifies
// them (load or sample, coefficient index check, effective tap count).
// ----------------------------------------------------------------------------
module fcm_front #(
  parameter int MAX_TAPS = 64,
  parameter int TW       = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fcm_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  input  logic                              busy,
  input  logic                              q_ready,
  output logic                              q_push,
  output fcm_pkg::item_t                    q_item,
  output logic [TW-1:0]                     q_taps,
  output logic [fcm_pkg::SHIFT_W-1:0]       shift
);

  logic [fcm_pkg::TAP_CNT_W-1:0] taps_cfg_r;
  logic [fcm_pkg::SHIFT_W-1:0]   shift_r;
  logic [31:0]                   tc_ext;
  logic [31:0]                   idx_ext;

  assign cfg_ready = 1'b1;
  assign shift     = shift_r;
  assign in_tready = q_ready && !busy;
  assign q_push    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_cfg_r <= 7'd64;
      shift_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fcm_pkg::REG_TAP_COUNT:    taps_cfg_r <= cfg_data;
        fcm_pkg::REG_OUTPUT_SHIFT: shift_r    <= cfg_data[fcm_pkg::SHIFT_W-1:0];
      endcase
    end
  end

  always_comb begin
    tc_ext  = 32'(taps_cfg_r);
    idx_ext = 32'(in_tdata[fcm_pkg::COEF_IDX_W-1:0]);
    if (tc_ext == 32'd0) begin
      q_taps = TW'(1);
    end else if (tc_ext > 32'(MAX_TAPS)) begin
      q_taps = TW'(MAX_TAPS);
    end else begin
      q_taps = TW'(tc_ext);
    end
    q_item.opcode   = in_tuser;
    q_item.coef_idx = in_tdata[fcm_pkg::COEF_IDX_W-1:0];
    q_item.value    = in_tdata[fcm_pkg::COEF_IDX_W +: fcm_pkg::DATA_W];
    q_item.coef_ok  = (idx_ext < 32'(MAX_TAPS));
  end

endmodule

[hdl/fcm_back.sv]
// ----------------------------------------------------------------------------
// fcm_back
// Coefficient and delay memories, shared MAC sequencer, rounding shift,
// clamp and output register. Clears both memories after reset.
// ----------------------------------------------------------------------------
module fcm_back #(
  parameter int MAX_TAPS = 64,
  parameter int TW       = 7,
  parameter int AW       = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  fcm_pkg::item_t                  q_item,
  input  logic [TW-1:0]                   q_taps,
  output logic                            q_pop,
  input  logic [fcm_pkg::SHIFT_W-1:0]     shift,
  output logic                            busy,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fcm_pkg::DATA_W-1:0]      out_tdata,
  output logic                            out_tuser
);

  localparam int ACC_W = 32 + AW;
  localparam int RW    = ACC_W + 1;
  localparam logic signed [RW-1:0] Y_MAX = RW'(32'sd32767);
  localparam logic signed [RW-1:0] Y_MIN = RW'(-32'sd32768);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_DRN  = 3'd3;
  localparam logic [2:0] S_RND  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic signed [fcm_pkg::DATA_W-1:0] coef_mem [MAX_TAPS];
  logic signed [fcm_pkg::DATA_W-1:0] dly_mem  [MAX_TAPS];

  logic [2:0]                        state_r, state_nxt;
  logic [AW-1:0]                     clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]                     wp_r, wp_nxt;
  logic [TW-1:0]                     taps_r, taps_nxt;
  logic [AW-1:0]                     ci_r, ci_nxt;
  logic [AW-1:0]                     di_r, di_nxt;
  logic [TW-1:0]                     cnt_r, cnt_nxt;
  logic                              v1_r, v2_r;
  logic signed [fcm_pkg::DATA_W-1:0] coef_rd_r, dly_rd_r;
  logic signed [31:0]                prod_r;
  logic signed [ACC_W-1:0]           acc_r, acc_nxt;
  logic signed [RW-1:0]              rnd_r;
  logic                              out_valid_r;
  logic [fcm_pkg::DATA_W-1:0]        out_data_r;
  logic                              out_sat_r;

  logic                              coef_we, dly_we;
  logic [AW-1:0]                     coef_wa, dly_wa;
  logic signed [fcm_pkg::DATA_W-1:0] coef_wd, dly_wd;
  logic [AW-1:0]                     pos;
  logic                              issue;
  logic                              out_free;
  logic                              out_load;
  logic signed [RW-1:0]              rnd_add;
  logic signed [RW-1:0]              sh_y;
  logic [fcm_pkg::DATA_W-1:0]        clamp_y;
  logic                              clamp_sat;

  assign busy       = (state_r == S_CLR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
  assign out_free   = !out_valid_r || out_tready;
  assign out_load   = (state_r == S_OUT) && out_free;
  assign issue      = (state_r == S_MAC);
  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign pos        = (TW'(wp_r) >= q_taps) ? '0 : wp_r;

  // memory write ports: clearing pass, coefficient load, sample store
  always_comb begin
    coef_we = 1'b0;
    coef_wa = AW'(q_item.coef_idx);
    coef_wd = q_item.value;
    dly_we  = 1'b0;
    dly_wa  = pos;
    dly_wd  = q_item.value;
    if (state_r == S_CLR) begin
      coef_we = 1'b1;
      coef_wa = clr_cnt_r;
      coef_wd = '0;
      dly_we  = 1'b1;
      dly_wa  = clr_cnt_r;
      dly_wd  = '0;
    end else if (q_pop) begin
      coef_we = (q_item.opcode == fcm_pkg::OP_LOAD) && q_item.coef_ok;
      dly_we  = (q_item.opcode == fcm_pkg::OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    coef_rd_r <= coef_mem[ci_r];
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_wa] <= dly_wd;
    end
    dly_rd_r <= dly_mem[di_r];
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    wp_nxt      = wp_r;
    taps_nxt    = taps_r;
    ci_nxt      = ci_r;
    di_nxt      = di_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = v2_r ? acc_r + ACC_W'(prod_r) : acc_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_cnt_r == AW'(MAX_TAPS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (q_valid && (q_item.opcode == fcm_pkg::OP_SAMPLE)) begin
          taps_nxt  = q_taps;
          ci_nxt    = '0;
          di_nxt    = pos;
          cnt_nxt   = '0;
          acc_nxt   = '0;
          wp_nxt    = ((TW'(pos) + TW'(1)) == q_taps) ? '0 : pos + AW'(1);
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        ci_nxt  = ci_r + AW'(1);
        di_nxt  = (di_r == '0) ? AW'(taps_r - TW'(1)) : di_r - AW'(1);
        cnt_nxt = cnt_r + TW'(1);
        if (cnt_r == taps_r - TW'(1)) begin
          state_nxt = S_DRN;
        end
      end
      S_DRN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // round half up, arithmetic shift, clamp to 16 bits
  always_comb begin
    rnd_add = '0;
    if (shift != '0) begin
      rnd_add = RW'(1) << (shift - fcm_pkg::SHIFT_W'(1));
    end
    sh_y      = rnd_r >>> shift;
    clamp_sat = 1'b0;
    clamp_y   = sh_y[fcm_pkg::DATA_W-1:0];
    if (sh_y > Y_MAX) begin
      clamp_y   = Y_MAX[fcm_pkg::DATA_W-1:0];
      clamp_sat = 1'b1;
    end else if (sh_y < Y_MIN) begin
      clamp_y   = Y_MIN[fcm_pkg::DATA_W-1:0];
      clamp_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      wp_r        <= '0;
      ci_r        <= '0;
      di_r        <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      wp_r      <= wp_nxt;
      ci_r      <= ci_nxt;
      di_r      <= di_nxt;
      v1_r      <= issue;
      v2_r      <= v1_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    taps_r <= taps_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    prod_r <= coef_rd_r * dly_rd_r;
    if (state_r == S_RND) begin
      rnd_r <= RW'(acc_r) + rnd_add;
    end
    if (out_load) begin
      out_data_r <= clamp_y;
      out_sat_r  <= clamp_sat;
    end
  end

endmodule

[hdl/fcm_checker.sv]
// ----------------------------------------------------------------------------
// fcm_checker
// Port-level checks of the FIR MAC core, bound to the top level.
// ----------------------------------------------------------------------------
module fcm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [fcm_pkg::DATA_W-1:0]     out_tdata,
  input logic                           out_tuser
);

  // held result word must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // memories are being cleared right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted during clearing pass");

  // saturation flag only with a clamp limit
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == 16'h7fff) || (out_tdata == 16'h8000))
    else $error("saturated flag with unclamped value");

  // no result can appear in the first cycle after reset
  a_no_early_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word straight after reset");

endmodule

bind fir_filter_circular_mac_core fcm_checker u_fcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[test/fir_filter_circular_mac_checker.sv]
// ----------------------------------------------------------------------------
// fir_filter_circular_mac_checker
// Watches the config, input and result channels of the FIR MAC core, keeps
// its own copy of the coefficient and delay stores, predicts each filtered
// sample and compares it with the result words in order.
// ----------------------------------------------------------------------------
module fir_filter_circular_mac_checker #(
  parameter int MAX_TAPS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [fcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [fcm_pkg::IN_TDATA_W-1:0]   in_tdata,   // coef_index, value, pad
  input  logic                             in_tuser,   // opcode
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [fcm_pkg::DATA_W-1:0]       out_tdata,  // sample_out
  input  logic                             out_tuser,  // saturated
  output int                               fail_count,
  output int                               pending
);
  import fcm_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] sample;
    logic                     saturated;
  } filtered_t;

  logic signed [DATA_W-1:0] dly_hist [MAX_TAPS];
  logic signed [DATA_W-1:0] coefs    [MAX_TAPS];
  int unsigned              write_pos;
  logic [TAP_CNT_W-1:0]     taps_reg;
  logic [SHIFT_W-1:0]       shift_reg;
  filtered_t                expected_samples [$];
  int                       failures = 0;

  task automatic flag_failure(input string msg);
    failures++;
    if (failures <= 10) $display("ERROR: %s", msg);
  endtask

  // one sample through the delay line and MAC, then round, shift and clamp
  function automatic void filter_sample(input logic signed [DATA_W-1:0] x);
    int unsigned ntaps;
    int unsigned pos;
    longint      acc;
    filtered_t   res;
    ntaps = (taps_reg == 0) ? 1 : ((taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg);
    pos   = (write_pos >= ntaps) ? 0 : write_pos;
    dly_hist[pos] = x;
    acc = 0;
    for (int unsigned i = 0; i < ntaps; i++)
      acc += longint'(coefs[i]) * longint'(dly_hist[(pos + ntaps - i) % ntaps]);
    write_pos = (pos + 1) % ntaps;
    if (shift_reg != 0) begin
      acc += longint'(1) << (shift_reg - 1);
      acc = acc >>> shift_reg;
    end
    res.saturated = 1'b1;
    if (acc > 32767) begin
      res.sample = 16'sh7fff;
    end else if (acc < -32768) begin
      res.sample = 16'sh8000;
    end else begin
      res.sample    = DATA_W'(acc);
      res.saturated = 1'b0;
    end
    expected_samples.push_back(res);
  endfunction

  always @(posedge clk) begin
    filtered_t want;
    if (!rst_n) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        dly_hist[k] = '0;
        coefs[k]    = '0;
      end
      write_pos = 0;
      taps_reg  = TAP_CNT_W'(64);
      shift_reg = '0;
      expected_samples.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          flag_failure($sformatf("result word with none expected: y=%0d sat=%0b",
                                 $signed(out_tdata), out_tuser));
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata !== want.sample || out_tuser !== want.saturated)
            flag_failure($sformatf("expected y=%0d sat=%0b, got y=%0d sat=%0b",
                                   want.sample, want.saturated,
                                   $signed(out_tdata), out_tuser));
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_LOAD)
          coefs[in_tdata[COEF_IDX_W-1:0]] = in_tdata[COEF_IDX_W +: DATA_W];
        else
          filter_sample(in_tdata[COEF_IDX_W +: DATA_W]);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TAP_COUNT)
          taps_reg = cfg_data[TAP_CNT_W-1:0];
        else if (cfg_index == REG_OUTPUT_SHIFT)
          shift_reg = cfg_data[SHIFT_W-1:0];
      end
    end
    pending    <= expected_samples.size();
    fail_count <= failures;
  end

endmodule

[test/tb_fir_filter_circular_mac_core.sv]
// ----------------------------------------------------------------------------
// tb_fir_filter_circular_mac_core
// Drives coefficient loads, samples and register writes into the FIR MAC
// core with random idling on both sides; the checker beside the core
// predicts every filtered sample and counts mismatches.
// ----------------------------------------------------------------------------
module tb_fir_filter_circular_mac_core;
  import fcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int SEG_WORDS      = 45;
  localparam int SEG_TAPS   [9] = '{1, 64, 8, 0, 5, 127, 33, 16, 2};
  localparam int SEG_SHIFTS [9] = '{0, 31, 15, 14, 16, 8, 20, 12, 1};

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    in_tuser;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [DATA_W-1:0]       out_tdata;
  logic                    out_tuser;

  int          fail_count;
  int          pending;
  int          tx_idle_pct = 9;
  int          rx_idle_pct = 79;
  int          quiet_cycles = 0;
  int unsigned taps_now = 64;

  always #4 clk = ~clk;

  fir_filter_circular_mac_core dut (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  fir_filter_circular_mac_checker checker_i (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .fail_count, .pending
  );

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // valid is left high after the handshake; gaps lower it
  task automatic send_word(input logic op, input logic [COEF_IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned taps, input int unsigned shift);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TAP_COUNT;
    cfg_data  <= taps[TAP_CNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_OUTPUT_SHIFT;
    cfg_data  <= CFG_DATA_W'(shift[SHIFT_W-1:0]);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    taps_now = taps;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3:    return DATA_W'($urandom_range(0, 511) - 256);
      default: return DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic                  op;
    logic [COEF_IDX_W-1:0] idx;
    int unsigned           ntaps;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TAP_COUNT;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_SAMPLE;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: 64 taps, no shift
    send_word(OP_LOAD, 6'd0, 16'h7fff);
    send_word(OP_LOAD, 6'd63, 16'h8000);
    send_word(OP_LOAD, 6'd1, 16'hffff);
    send_word(OP_SAMPLE, 6'h3f, 16'h7fff);
    send_word(OP_SAMPLE, 6'd0, 16'h8000);
    send_word(OP_SAMPLE, 6'd0, 16'h0000);
    send_word(OP_SAMPLE, 6'h2a, 16'h0001);
    // fewer taps than the write position: position restarts at zero
    wait_drained();
    set_config(3, 1);
    send_word(OP_SAMPLE, 6'd0, 16'h8000);
    send_word(OP_SAMPLE, 6'd0, 16'h7fff);
    send_word(OP_SAMPLE, 6'd0, 16'h1234);
    // zero taps acts as one, widest shift
    wait_drained();
    set_config(0, 31);
    send_word(OP_SAMPLE, 6'd0, 16'h8000);
    send_word(OP_SAMPLE, 6'd0, 16'h7fff);
    // tap count above the maximum
    wait_drained();
    set_config(127, 0);
    send_word(OP_LOAD, 6'd2, 16'h4000);
    send_word(OP_SAMPLE, 6'd0, 16'h0064);
    send_word(OP_SAMPLE, 6'd0, 16'hfffb);

    for (int seg = 0; seg < 9; seg++) begin
      tx_idle_pct = (seg < 3) ? 9 : ((seg < 6) ? 79 : 0);
      rx_idle_pct = (seg < 3) ? 79 : ((seg < 6) ? 9 : 0);
      wait_drained();
      set_config(SEG_TAPS[seg], SEG_SHIFTS[seg]);
      ntaps = (taps_now == 0) ? 1 : ((taps_now > 64) ? 64 : taps_now);
      for (int n = 0; n < SEG_WORDS; n++) begin
        op  = ($urandom_range(0, 99) < 30) ? OP_LOAD : OP_SAMPLE;
        idx = ($urandom_range(0, 3) == 0) ? COEF_IDX_W'($urandom_range(0, 63))
                                          : COEF_IDX_W'($urandom_range(0, ntaps - 1));
        send_word(op, idx, pick_value());
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
